### rtl/core/rclc_pkg.sv
// Package for the rolling code lock controller: table depth, pointer type,
// opcode and register index codes, and the structs passed between modules.
// No dependencies.
`default_nettype none

package rclc_pkg;

  localparam int unsigned CODE_DEPTH = 256;
  localparam int unsigned PTR_W      = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;

  localparam logic [15:0] TIMEOUT_RESET   = 16'd32000;
  localparam logic [7:0]  LOCATE_RESET    = 8'hFE;
  localparam logic [7:0]  HANDSHAKE_RESET = 8'hFF;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MSG  = 2'd1,
    OP_LOAD = 2'd2,
    OP_NOP  = 2'd3
  } rclc_op_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_LOCATE    = 2'd1,
    CFG_HANDSHAKE = 2'd2
  } rclc_cfg_e;

  typedef struct packed {
    logic        unlocked;
    ptr_t        ptr;
    logic [15:0] timeout;
    logic        pending;
  } rclc_state_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  locate_command;
    logic [7:0]  handshake_command;
  } rclc_cfg_t;

  typedef struct packed {
    logic        is_unlocked;
    logic        send_reply;
    logic        flash_locate;
    logic        engine_light;
    logic        blink_lock_light;
    logic [7:0]  code_position;
  } rclc_result_t;

  typedef struct packed {
    logic       en;
    ptr_t       addr;
    logic [7:0] data;
  } rclc_wr_t;

  // The pointer wraps from the last table entry back to the first.
  function automatic ptr_t next_ptr(ptr_t p);
    return (p == PTR_W'(CODE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [7:0] pos_of(ptr_t p);
    logic [31:0] ext;
    ext = 32'(p);
    return ext[7:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/rclc_code_ram.sv
// Code table storage: one write port and one registered read port.
// A write to the address being read is forwarded to the read data.
// Depends on rclc_pkg.
`default_nettype none

module rclc_code_ram
  import rclc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire rclc_wr_t wr_i,
  input  wire ptr_t     rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [CODE_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/rclc_step.sv
// Per-event decision logic: from the current state, settings, the expected
// code and one event it forms the next state, the table write and the result.
// Depends on rclc_pkg.
`default_nettype none

module rclc_step
  import rclc_pkg::*;
(
  input  wire rclc_state_t  state_i,
  input  wire rclc_cfg_t    cfg_i,
  input  wire logic [7:0]   cur_code_i,
  input  wire logic [1:0]   opcode_i,
  input  wire logic [7:0]   message_i,
  input  wire logic         strong_signal_i,
  input  wire logic         main_switch_i,
  input  wire logic [7:0]   entry_index_i,
  input  wire logic [7:0]   entry_value_i,
  output rclc_state_t       state_o,
  output rclc_wr_t          wr_o,
  output rclc_result_t      result_o
);

  logic        reply;
  logic        flash;
  logic        blink;
  logic [15:0] tmo;
  logic        pend;
  logic [31:0] idx_ext;

  always_comb begin
    state_o = state_i;
    reply   = 1'b0;
    flash   = 1'b0;
    blink   = 1'b0;
    tmo     = state_i.timeout;
    pend    = state_i.pending;
    idx_ext = 32'(entry_index_i);
    wr_o.en   = 1'b0;
    wr_o.addr = idx_ext[PTR_W-1:0];
    wr_o.data = entry_value_i;

    unique case (rclc_op_e'(opcode_i))
      OP_LOAD: begin
        wr_o.en = (idx_ext < CODE_DEPTH);
      end
      OP_TICK, OP_MSG: begin
        if (!state_i.unlocked) begin
          // The locate check wins over a code match while locked.
          if (rclc_op_e'(opcode_i) == OP_MSG) begin
            if (message_i == cfg_i.locate_command) begin
              flash = 1'b1;
            end else if (message_i == cur_code_i) begin
              reply            = 1'b1;
              state_o.unlocked = 1'b1;
              state_o.timeout  = cfg_i.timeout_ticks;
              state_o.pending  = 1'b0;
              state_o.ptr      = next_ptr(state_i.ptr);
            end
          end
        end else begin
          if (rclc_op_e'(opcode_i) == OP_MSG) begin
            // Weak messages are ignored and do not count as a tick.
            if (strong_signal_i) begin
              if (message_i == cfg_i.handshake_command) begin
                reply = 1'b1;
                blink = 1'b1;
                pend  = 1'b0;
                tmo   = cfg_i.timeout_ticks;
              end else if ((message_i == cur_code_i) && !main_switch_i) begin
                reply = 1'b1;
                pend  = 1'b1;
              end
            end
          end else if (tmo != 16'd0) begin
            tmo = tmo - 16'd1;
          end
          if (tmo == 16'd0) begin
            pend = 1'b1;
          end
          state_o.timeout = tmo;
          state_o.pending = pend;
          if (pend && !main_switch_i) begin
            state_o.unlocked = 1'b0;
            state_o.pending  = 1'b0;
            state_o.ptr      = next_ptr(state_i.ptr);
          end
        end
      end
      default: begin
      end
    endcase

    result_o.is_unlocked      = state_o.unlocked;
    result_o.send_reply       = reply;
    result_o.flash_locate     = flash;
    result_o.engine_light     = state_i.unlocked & main_switch_i;
    result_o.blink_lock_light = blink;
    result_o.code_position    = pos_of(state_o.ptr);
  end

endmodule

`default_nettype wire

### rtl/core/rolling_code_lock_controller.sv
// Rolling code lock controller, top level.
// Depends on rclc_pkg, rclc_code_ram and rclc_step.
//
// Usage: events enter on the input channel (in_valid_i / in_stall_o) and each
// one gives exactly one result beat on the output channel (out_valid_o /
// out_stall_i). Opcode 0 is an idle tick, 1 a received radio message, 2 loads
// one code table byte, 3 only reports status. Settings are written through
// the cfg port (index 0 timeout ticks, 1 locate command, 2 handshake command)
// while no event is in flight; cfg_ready_o is always high.
// An accepted event's result is registered in the output register, or in the
// skid register while the output holds a beat not yet taken. One event per
// cycle is accepted while in_stall_o is low; each is decided by one pass of
// combinational logic between the state registers and the result registers,
// with the expected code held ready by the table's read port. Once the skid
// register is full, in_stall_o rises until its result moves to the output.
// Reset: locked, code pointer 0, timeout 0, settings at their defaults.
// The code table is not cleared; load every entry that will be used.
`default_nettype none

module rolling_code_lock_controller
  import rclc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  message_i,
  input  wire logic        strong_signal_i,
  input  wire logic        main_switch_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [7:0]  entry_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_unlocked_o,
  output logic             send_reply_o,
  output logic             flash_locate_o,
  output logic             engine_light_o,
  output logic             blink_lock_light_o,
  output logic [7:0]       code_position_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  rclc_state_t  state_q, state_d, step_state;
  rclc_cfg_t    cfg_q;
  rclc_wr_t     step_wr, ram_wr;
  rclc_result_t step_res;
  rclc_result_t out_q, out_d, skid_q, skid_d;
  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  logic         in_accept, out_pop;
  logic [7:0]   cur_code;
  ptr_t         rd_addr;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i & ~skid_valid_q;
  assign out_pop     = out_valid_q & ~out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Settings registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks     <= TIMEOUT_RESET;
      cfg_q.locate_command    <= LOCATE_RESET;
      cfg_q.handshake_command <= HANDSHAKE_RESET;
    end else if (cfg_valid_i) begin
      unique case (rclc_cfg_e'(cfg_index_i))
        CFG_TIMEOUT:   cfg_q.timeout_ticks     <= cfg_data_i;
        CFG_LOCATE:    cfg_q.locate_command    <= cfg_data_i[7:0];
        CFG_HANDSHAKE: cfg_q.handshake_command <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  rclc_step u_step (
    .state_i         (state_q),
    .cfg_i           (cfg_q),
    .cur_code_i      (cur_code),
    .opcode_i        (opcode_i),
    .message_i       (message_i),
    .strong_signal_i (strong_signal_i),
    .main_switch_i   (main_switch_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .state_o         (step_state),
    .wr_o            (step_wr),
    .result_o        (step_res)
  );

  // The read port always looks up the entry for the next pointer, so the
  // expected code is ready when the following event arrives.
  assign rd_addr = state_d.ptr;

  always_comb begin
    ram_wr    = step_wr;
    ram_wr.en = step_wr.en & in_accept;
  end

  rclc_code_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (cur_code)
  );

  assign state_d = in_accept ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_pop) begin
        out_d       = step_res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = step_res;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o        = out_valid_q;
  assign is_unlocked_o      = out_q.is_unlocked;
  assign send_reply_o       = out_q.send_reply;
  assign flash_locate_o     = out_q.flash_locate;
  assign engine_light_o     = out_q.engine_light;
  assign blink_lock_light_o = out_q.blink_lock_light;
  assign code_position_o    = out_q.code_position;

endmodule

`default_nettype wire

### rtl/core/rclc_checker.sv
// Port-level checks for the rolling code lock controller, and the bind that
// attaches them to the top level. Depends on rolling_code_lock_controller.
`default_nettype none

module rclc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic is_unlocked_o,
  input wire logic send_reply_o,
  input wire logic flash_locate_o,
  input wire logic blink_lock_light_o
);

  // The block only holds off input once a result is already waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result beat dropped");

  // A locate flash is only given while locked, and it never unlocks.
  a_flash_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flash_locate_o) |-> (!is_unlocked_o && !send_reply_o))
    else $error("locate flash together with unlock or reply");

  a_blink_replies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && blink_lock_light_o) |-> send_reply_o)
    else $error("lock light blink without a handshake reply");

endmodule

bind rolling_code_lock_controller rclc_checker u_rclc_checker (.*);

`default_nettype wire

### bench/tb.sv
// Testbench for rolling_code_lock_controller: table fill, directed table, then random
// phases checked beat by beat against a predictor of lock mode, code pointer and timeout.
// Depends on rclc_pkg and the RTL of the controller.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rclc_pkg::*;

  localparam int DIRECTED_ROWS     = 23;
  localparam int SHORT_TIMEOUT_ROW = 16;
  localparam int RANDOM_PHASES     = 6;
  localparam int EVENTS_PER_PHASE  = 212;
  localparam int QUIET_LIMIT       = 1000;
  localparam int PRINT_LIMIT       = 20;

  typedef struct packed {
    rclc_op_e   op;
    logic [7:0] message;
    logic       strong_sig;
    logic       sw;
    logic [7:0] entry_index;
    logic [7:0] entry_value;
  } lock_event_t;

  typedef struct packed {
    lock_event_t  ev;
    logic         typed;
    rclc_result_t want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [7:0]  message_i = '0;
  logic        strong_signal_i = 1'b0;
  logic        main_switch_i = 1'b0;
  logic [7:0]  entry_index_i = '0;
  logic [7:0]  entry_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        is_unlocked_o;
  logic        send_reply_o;
  logic        flash_locate_o;
  logic        engine_light_o;
  logic        blink_lock_light_o;
  logic [7:0]  code_position_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  rolling_code_lock_controller u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .message_i          (message_i),
    .strong_signal_i    (strong_signal_i),
    .main_switch_i      (main_switch_i),
    .entry_index_i      (entry_index_i),
    .entry_value_i      (entry_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .is_unlocked_o      (is_unlocked_o),
    .send_reply_o       (send_reply_o),
    .flash_locate_o     (flash_locate_o),
    .engine_light_o     (engine_light_o),
    .blink_lock_light_o (blink_lock_light_o),
    .code_position_o    (code_position_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: mirrors the vehicle side of the protocol.
  logic        car_open = 1'b0;
  ptr_t        code_ptr = '0;
  logic [15:0] countdown = '0;
  logic        lock_req = 1'b0;
  logic [7:0]  code_mem [CODE_DEPTH];
  rclc_cfg_t   settings = '{TIMEOUT_RESET, LOCATE_RESET, HANDSHAKE_RESET};

  rclc_result_t status_q [$];
  int send_idle_pct = 22;
  int stall_pct = 45;
  int mismatches = 0;
  int events_sent = 0;
  int results_seen = 0;
  int unlocks = 0;
  int wraps = 0;
  int settings_used = 1;

  script_row_t script [DIRECTED_ROWS];

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  function automatic void step_pointer();
    if (code_ptr == ptr_t'(CODE_DEPTH - 1)) begin
      code_ptr = '0;
      wraps++;
    end else begin
      code_ptr = code_ptr + 1'b1;
    end
  endfunction

  function automatic rclc_result_t predict_status(lock_event_t ev);
    rclc_result_t r;
    logic was_open;
    r = '0;
    was_open = car_open;
    if (was_open) r.engine_light = ev.sw;
    case (ev.op)
      OP_LOAD: begin
        if (int'(ev.entry_index) < CODE_DEPTH) code_mem[ev.entry_index] = ev.entry_value;
      end
      OP_TICK, OP_MSG: begin
        if (!was_open) begin
          // The locate check wins, so a code equal to it never unlocks.
          if (ev.op == OP_MSG) begin
            if (ev.message == settings.locate_command) begin
              r.flash_locate = 1'b1;
            end else if (ev.message == code_mem[code_ptr]) begin
              r.send_reply = 1'b1;
              car_open = 1'b1;
              countdown = settings.timeout_ticks;
              lock_req = 1'b0;
              unlocks++;
              step_pointer();
            end
          end
        end else begin
          if (ev.op == OP_MSG) begin
            if (ev.strong_sig) begin
              if (ev.message == settings.handshake_command) begin
                r.send_reply = 1'b1;
                r.blink_lock_light = 1'b1;
                lock_req = 1'b0;
                countdown = settings.timeout_ticks;
              end else if (ev.message == code_mem[code_ptr] && !ev.sw) begin
                r.send_reply = 1'b1;
                lock_req = 1'b1;
              end
            end
          end else if (countdown != 0) begin
            countdown = countdown - 1'b1;
          end
          if (countdown == 0) lock_req = 1'b1;
          if (lock_req && !ev.sw) begin
            car_open = 1'b0;
            lock_req = 1'b0;
            step_pointer();
          end
        end
      end
      default: ;
    endcase
    r.is_unlocked = car_open;
    r.code_position = 8'(code_ptr);
    return r;
  endfunction

  // Mostly well-formed unlock, handshake and lock sequences, the rest noise.
  function automatic lock_event_t pick_event();
    lock_event_t ev;
    int unsigned roll;
    ev.op = rclc_op_e'($urandom_range(3));
    ev.message = 8'($urandom_range(255));
    ev.strong_sig = 1'($urandom_range(1));
    ev.sw = 1'($urandom_range(1));
    ev.entry_index = 8'($urandom_range(255));
    ev.entry_value = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (!car_open) begin
      if (roll < 55) begin
        ev.op = OP_MSG;
        ev.message = code_mem[code_ptr];
      end else if (roll < 65) begin
        ev.op = OP_MSG;
        ev.message = settings.locate_command;
      end else if (roll < 75) begin
        ev.op = OP_MSG;
      end
    end else begin
      ev.sw = ($urandom_range(99) < 30);
      if (roll < 35) begin
        ev.op = OP_TICK;
      end else if (roll < 55) begin
        ev.op = OP_MSG;
        ev.strong_sig = 1'b1;
        ev.message = settings.handshake_command;
      end else if (roll < 70) begin
        ev.op = OP_MSG;
        ev.message = code_mem[code_ptr];
        ev.strong_sig = ($urandom_range(9) != 0);
      end else if (roll < 78) begin
        ev.op = OP_MSG;
      end
    end
    return ev;
  endfunction

  task automatic send_event(lock_event_t ev, logic typed, rclc_result_t want);
    rclc_result_t predicted;
    in_valid_i <= 1'b1;
    opcode_i <= ev.op;
    message_i <= ev.message;
    strong_signal_i <= ev.strong_sig;
    main_switch_i <= ev.sw;
    entry_index_i <= ev.entry_index;
    entry_value_i <= ev.entry_value;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_status(ev);
    status_q.push_back(typed ? want : predicted);
    events_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Every event gives one beat, so an empty queue means the block is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(rclc_cfg_e sel, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (sel)
      CFG_TIMEOUT:   settings.timeout_ticks = data;
      CFG_LOCATE:    settings.locate_command = data[7:0];
      CFG_HANDSHAKE: settings.handshake_command = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    rclc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) begin
        report_mismatch("result beat with no event waiting");
      end else begin
        want = status_q.pop_front();
        compare_field("is_unlocked", 8'(is_unlocked_o), 8'(want.is_unlocked));
        compare_field("send_reply", 8'(send_reply_o), 8'(want.send_reply));
        compare_field("flash_locate", 8'(flash_locate_o), 8'(want.flash_locate));
        compare_field("engine_light", 8'(engine_light_o), 8'(want.engine_light));
        compare_field("blink_lock_light", 8'(blink_lock_light_o),
                      8'(want.blink_lock_light));
        compare_field("code_position", code_position_o, want.code_position);
        results_seen++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    lock_event_t ev;
    logic [15:0] tmo;
    logic [7:0]  loc;
    logic [7:0]  hs;

    // op, message, strong, switch, index, value | typed,
    // unlocked/reply/flash/engine/blink, position
    script[0]  = {OP_NOP,  8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 1'b1, 5'b00000, 8'd0};
    script[1]  = {OP_TICK, 8'hA5, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1, 5'b00000, 8'd0};
    script[2]  = {OP_LOAD, 8'h00, 1'b0, 1'b0, 8'h00, 8'hFE, 1'b1, 5'b00000, 8'd0};
    // Entry 0 equals the locate command: flash only, no unlock.
    script[3]  = {OP_MSG,  8'hFE, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 5'b00100, 8'd0};
    script[4]  = {OP_LOAD, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    script[5]  = {OP_LOAD, 8'h00, 1'b0, 1'b0, 8'h01, 8'hFF, 1'b0, 5'b00000, 8'd0};
    script[6]  = {OP_LOAD, 8'h00, 1'b0, 1'b0, 8'hFF, 8'h5A, 1'b0, 5'b00000, 8'd0};
    script[7]  = {OP_MSG,  8'h01, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    script[8]  = {OP_MSG,  8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 1'b1, 5'b11000, 8'd1};
    script[9]  = {OP_TICK, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    // A weak message while unlocked is not an idle tick.
    script[10] = {OP_MSG,  8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    // Handshake is checked before the code, which holds the same value here.
    script[11] = {OP_MSG,  8'hFF, 1'b1, 1'b1, 8'h00, 8'h00, 1'b1, 5'b11011, 8'd1};
    script[12] = {OP_MSG,  8'hFE, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    script[13] = {OP_LOAD, 8'h00, 1'b0, 1'b1, 8'h01, 8'h3C, 1'b0, 5'b00000, 8'd0};
    script[14] = {OP_MSG,  8'h3C, 1'b1, 1'b1, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    script[15] = {OP_MSG,  8'h3C, 1'b1, 1'b0, 8'h00, 8'h00, 1'b1, 5'b01000, 8'd2};
    // From here the timeout is a single tick.
    script[16] = {OP_LOAD, 8'h00, 1'b0, 1'b0, 8'h02, 8'h80, 1'b0, 5'b00000, 8'd0};
    script[17] = {OP_MSG,  8'h80, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    script[18] = {OP_TICK, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 5'b00000, 8'd0};
    // The countdown sits at zero; the switch holds the lock off.
    script[19] = {OP_TICK, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 1'b1, 5'b10010, 8'd3};
    // Neither a load nor a status step evaluates the pending lock.
    script[20] = {OP_LOAD, 8'h00, 1'b0, 1'b0, 8'h03, 8'h11, 1'b0, 5'b00000, 8'd0};
    script[21] = {OP_NOP,  8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 5'b10000, 8'd3};
    script[22] = {OP_TICK, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 5'b00000, 8'd4};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole table first so that no code lookup reads an empty entry.
    for (int i = 0; i < CODE_DEPTH; i++) begin
      ev = pick_event();
      ev.op = OP_LOAD;
      ev.entry_index = 8'(i);
      send_event(ev, 1'b0, '0);
    end

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == SHORT_TIMEOUT_ROW) begin
        drain();
        write_reg(CFG_TIMEOUT, 16'd1);
        settings_used++;
      end
      send_event(script[i].ev, script[i].typed, script[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p / 2)
        0:       begin send_idle_pct = 22; stall_pct = 45; end
        1:       begin send_idle_pct = 45; stall_pct = 22; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      case (p)
        0: begin tmo = 16'd1;     loc = 8'h00; hs = 8'hFF; end
        1: begin tmo = 16'd65535; loc = 8'hFF; hs = 8'h00; end
        5: begin
          tmo = 16'($urandom_range(13, 400));
          loc = 8'($urandom_range(255));
          hs = 8'($urandom_range(255));
        end
        default: begin
          tmo = 16'($urandom_range(2, 12));
          loc = 8'($urandom_range(255));
          hs = 8'($urandom_range(255));
        end
      endcase
      write_reg(CFG_TIMEOUT, tmo);
      write_reg(CFG_LOCATE, {8'h00, loc});
      write_reg(CFG_HANDSHAKE, {8'h00, hs});
      settings_used++;
      for (int n = 0; n < EVENTS_PER_PHASE; n++) send_event(pick_event(), 1'b0, '0);
    end

    drain();
    $display("Checked %0d result beats from %0d events under %0d register settings.",
             results_seen, events_sent, settings_used);
    $display("The code pointer advanced through %0d unlocks and wrapped %0d times.",
             unlocks, wraps);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
